// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the scaler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define NNFS_ASSERT(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (prop)) \
		else $error(msg);

// Antecedent at one edge implies the consequent at the next edge.
`define NNFS_ASSERT_NEXT(label, clk_sig, rst_n_sig, ante, cons, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) \
		(ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/nnfs_pkg.sv
// Package for the nearest-neighbour frame scaler: sizes, codes and state type.
package nnfs_pkg;

	// Default build sizes
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int DEF_PIXEL_BITS = 24;

	// Fixed port widths
	localparam int CFG_W      = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int PIX_OUT_W  = 24;
	localparam int PIX_IN_W   = 24;
	localparam int POS_OUT_W  = 10;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SRC_W = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_H = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DST_W = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DST_H = 2'd3;

	localparam logic [CFG_W-1:0] DIM_RESET = 11'd1024;

	// Command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EMIT = 1'b1;

	// Emit sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_ADDR,
		ST_OUT
	} state_t;

endpackage

// File: rtl/core/nnfs_ram.sv
// Generic simple dual-port RAM with registered read data.
module nnfs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/nnfs_div.sv
// Restoring divider, one quotient bit per cycle.
module nnfs_div #(
	parameter int DVD_W = 21,
	parameter int DVS_W = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic [DVD_W-1:0] quotient,
	output logic             done
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;

	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;
	logic [DVS_W-1:0] rem_next;

	// One trial subtraction; remainder stays below the divisor
	always_comb begin
		trial    = {rem_q, quo_q[DVD_W-1]};
		diff     = trial - {1'b0, divisor};
		ge       = trial >= {1'b0, divisor};
		rem_next = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
	end

	// Step counter and finish pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(DVD_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CNT_W'(1);
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// Dividend shifts out as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= rem_next;
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// File: rtl/core/nearest_neighbor_frame_scaler.sv
// Nearest-neighbour frame scaler: frame store, load counters and emit sequencer.
//
// Input channel (in_valid/in_ready): each beat carries a command. A load beat
// writes pixel_in into the frame store at the next source raster position; it
// gives no result. An emit beat samples the source pixel
// for the next destination raster position and gives one output beat.
// Source coordinates are pos*src/dst, found with two restoring dividers run
// side by side, one quotient bit per cycle over the product width PW
// (position bits plus dimension bits, 21 at default sizes).
// An emit beat passes through the states MUL (divider start), DIV (until the
// dividers are done), ADDR (frame store read) and OUT (output register load);
// the input stays closed until the sequencer is back in IDLE.
// Output channel (out_valid/out_ready): the result sits in an output register,
// so a further load may be accepted while it waits; an emit that finishes
// while the receiver stalls holds in place until the register is free.
// Reset clears all counters and sets every size register to 1024. The frame
// store is not cleared; a never-written entry reads as anything.
// Configuration writes (cfg_write) take effect at once and belong to idle time.
module nearest_neighbor_frame_scaler #(
	parameter int MAX_WIDTH  = nnfs_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = nnfs_pkg::DEF_MAX_HEIGHT,
	parameter int PIXEL_BITS = nnfs_pkg::DEF_PIXEL_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [nnfs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nnfs_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           command,
	input  logic [nnfs_pkg::PIX_IN_W-1:0]  pixel_in,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [nnfs_pkg::PIX_OUT_W-1:0] pixel_out,
	output logic [nnfs_pkg::POS_OUT_W-1:0] target_x,
	output logic [nnfs_pkg::POS_OUT_W-1:0] target_y,
	output logic                           frame_last,
	output logic                           source_complete
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int PSW   = (CW > RW) ? CW : RW;
	localparam int MW1   = $clog2(MAX_WIDTH + 1);
	localparam int MH1   = $clog2(MAX_HEIGHT + 1);
	localparam int MD    = (MW1 > MH1) ? MW1 : MH1;
	localparam int DW    = (MD > nnfs_pkg::CFG_W) ? MD : nnfs_pkg::CFG_W;
	localparam int PW    = PSW + DW;
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	nnfs_pkg::state_t state_q, state_nxt;

	logic [nnfs_pkg::CFG_W-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
	logic [DW-1:0] sw, sh, tw, th;

	logic [CW-1:0] load_col_q, emit_col_q;
	logic [RW-1:0] load_row_q, emit_row_q;
	logic          loaded_q;

	logic [CW-1:0] xpos_s1;
	logic [RW-1:0] ypos_s1;
	logic          last_s1;
	logic          loaded_s1;
	logic [CW-1:0] sx_s2;
	logic [RW-1:0] sy_s2;

	logic                           out_valid_q;
	logic [nnfs_pkg::PIX_OUT_W-1:0] pixel_out_q;
	logic [nnfs_pkg::POS_OUT_W-1:0] target_x_q, target_y_q;
	logic                           frame_last_q, source_complete_q;

	logic          accept, ld_accept, em_accept;
	logic [DW-1:0] lcol_inc, lrow_inc, ecol_inc, erow_inc;
	logic          lcol_wrap, lrow_wrap, row_end, frame_end;
	logic          div_start, div_done_x, div_done_y, ram_re, out_load;
	logic [PW-1:0] dvd_x, dvd_y, quo_x, quo_y;
	logic [AW-1:0] waddr, raddr;
	logic [PIXEL_BITS-1:0] rdata;

	// Size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= nnfs_pkg::DIM_RESET;
			src_h_q <= nnfs_pkg::DIM_RESET;
			dst_w_q <= nnfs_pkg::DIM_RESET;
			dst_h_q <= nnfs_pkg::DIM_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				nnfs_pkg::REG_SRC_W: src_w_q <= cfg_data;
				nnfs_pkg::REG_SRC_H: src_h_q <= cfg_data;
				nnfs_pkg::REG_DST_W: dst_w_q <= cfg_data;
				nnfs_pkg::REG_DST_H: dst_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective sizes: zero acts as one, oversize acts as the maximum
	assign sw = (src_w_q == '0) ? DW'(1) :
		(DW'(src_w_q) > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : DW'(src_w_q);
	assign sh = (src_h_q == '0) ? DW'(1) :
		(DW'(src_h_q) > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : DW'(src_h_q);
	assign tw = (dst_w_q == '0) ? DW'(1) :
		(DW'(dst_w_q) > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : DW'(dst_w_q);
	assign th = (dst_h_q == '0) ? DW'(1) :
		(DW'(dst_h_q) > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : DW'(dst_h_q);

	// Handshake decode
	assign accept    = in_valid && in_ready;
	assign ld_accept = accept && (command == nnfs_pkg::CMD_LOAD);
	assign em_accept = accept && (command == nnfs_pkg::CMD_EMIT);

	// Raster stepping for load and emit positions
	assign lcol_inc  = DW'(load_col_q) + DW'(1);
	assign lrow_inc  = DW'(load_row_q) + DW'(1);
	assign lcol_wrap = lcol_inc >= sw;
	assign lrow_wrap = lrow_inc >= sh;
	assign ecol_inc  = DW'(emit_col_q) + DW'(1);
	assign erow_inc  = DW'(emit_row_q) + DW'(1);
	assign row_end   = ecol_inc >= tw;
	assign frame_end = row_end && (erow_inc >= th);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_col_q <= '0;
			load_row_q <= '0;
			loaded_q   <= 1'b0;
			emit_col_q <= '0;
			emit_row_q <= '0;
		end else begin
			if (ld_accept) begin
				if (lcol_wrap) begin
					load_col_q <= '0;
					if (lrow_wrap) begin
						load_row_q <= '0;
						loaded_q   <= 1'b1;
					end else begin
						load_row_q <= RW'(lrow_inc);
					end
				end else begin
					load_col_q <= CW'(lcol_inc);
				end
			end
			if (em_accept) begin
				if (row_end) begin
					emit_col_q <= '0;
					emit_row_q <= frame_end ? '0 : RW'(erow_inc);
				end else begin
					emit_col_q <= CW'(ecol_inc);
				end
			end
		end
	end

	// Snapshot of the emitted position and its flags
	always_ff @(posedge clk) begin
		if (em_accept) begin
			xpos_s1   <= emit_col_q;
			ypos_s1   <= emit_row_q;
			last_s1   <= frame_end;
			loaded_s1 <= loaded_q;
		end
	end

	// Products feed the dividers directly
	assign dvd_x = PW'(PW'(xpos_s1) * PW'(sw));
	assign dvd_y = PW'(PW'(ypos_s1) * PW'(sh));

	nnfs_div #(
		.DVD_W (PW),
		.DVS_W (DW)
	) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd_x),
		.divisor  (tw),
		.quotient (quo_x),
		.done     (div_done_x)
	);

	nnfs_div #(
		.DVD_W (PW),
		.DVS_W (DW)
	) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd_y),
		.divisor  (th),
		.quotient (quo_y),
		.done     (div_done_y)
	);

	// Source coordinates, saturated to the last column and row
	always_ff @(posedge clk) begin
		if (state_q == nnfs_pkg::ST_DIV && div_done_x) begin
			sx_s2 <= (quo_x >= PW'(sw)) ? CW'(sw - DW'(1)) : CW'(quo_x);
			sy_s2 <= (quo_y >= PW'(sh)) ? RW'(sh - DW'(1)) : RW'(quo_y);
		end
	end

	// Frame store
	assign waddr = AW'(AW'(load_row_q) * AW'(MAX_WIDTH) + AW'(load_col_q));
	assign raddr = AW'(AW'(sy_s2) * AW'(MAX_WIDTH) + AW'(sx_s2));

	nnfs_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ld_accept),
		.waddr (waddr),
		.wdata (PIXEL_BITS'(pixel_in)),
		.re    (ram_re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nnfs_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			nnfs_pkg::ST_IDLE: if (em_accept) state_nxt = nnfs_pkg::ST_MUL;
			nnfs_pkg::ST_MUL:  state_nxt = nnfs_pkg::ST_DIV;
			nnfs_pkg::ST_DIV:  if (div_done_x) state_nxt = nnfs_pkg::ST_ADDR;
			nnfs_pkg::ST_ADDR: state_nxt = nnfs_pkg::ST_OUT;
			nnfs_pkg::ST_OUT:  if (!out_valid_q || out_ready) state_nxt = nnfs_pkg::ST_IDLE;
			default:           state_nxt = nnfs_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_ready  = 1'b0;
		div_start = 1'b0;
		ram_re    = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			nnfs_pkg::ST_IDLE: in_ready  = 1'b1;
			nnfs_pkg::ST_MUL:  div_start = 1'b1;
			nnfs_pkg::ST_DIV:  ;
			nnfs_pkg::ST_ADDR: ram_re    = 1'b1;
			nnfs_pkg::ST_OUT:  out_load  = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pixel_out_q       <= nnfs_pkg::PIX_OUT_W'(rdata);
			target_x_q        <= nnfs_pkg::POS_OUT_W'(xpos_s1);
			target_y_q        <= nnfs_pkg::POS_OUT_W'(ypos_s1);
			frame_last_q      <= last_s1;
			source_complete_q <= loaded_s1;
		end
	end

	assign out_valid       = out_valid_q;
	assign pixel_out       = pixel_out_q;
	assign target_x        = target_x_q;
	assign target_y        = target_y_q;
	assign frame_last      = frame_last_q;
	assign source_complete = source_complete_q;

endmodule

// File: rtl/core/nnfs_checker.sv
// Port-level checks for the frame scaler, bound to the top level.
`include "assert_macros.svh"

module nnfs_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cfg_write,
	input logic [nnfs_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [nnfs_pkg::CFG_W-1:0]     cfg_data,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           command,
	input logic [nnfs_pkg::PIX_IN_W-1:0]  pixel_in,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [nnfs_pkg::PIX_OUT_W-1:0] pixel_out,
	input logic [nnfs_pkg::POS_OUT_W-1:0] target_x,
	input logic [nnfs_pkg::POS_OUT_W-1:0] target_y,
	input logic                           frame_last,
	input logic                           source_complete
);

	logic ld_beat, em_beat;

	assign ld_beat = in_valid && in_ready && (command == nnfs_pkg::CMD_LOAD);
	assign em_beat = in_valid && in_ready && (command == nnfs_pkg::CMD_EMIT);

	// A stalled result beat holds its pixel and target position
	`NNFS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(pixel_out) && $stable(target_x) && $stable(target_y), "output beat changed while stalled")

	// A load never brings a new result
	`NNFS_ASSERT_NEXT(a_load_silent, clk, arst_n, ld_beat && !out_valid, !out_valid, "load beat produced a result")

	// An emit keeps the input closed while it is worked on
	`NNFS_ASSERT_NEXT(a_emit_busy, clk, arst_n, em_beat, !in_ready, "input taken during an emit")

	// Source-complete flag never falls back between results
	`NNFS_ASSERT(a_complete_sticky, clk, arst_n, $rose(out_valid) && $past(source_complete) |-> source_complete, "source complete flag dropped")

endmodule

bind nearest_neighbor_frame_scaler nnfs_checker u_nnfs_checker (.*);

// File: sim/tb_nearest_neighbor_frame_scaler.sv
`timescale 1ns / 1ps
// Testbench for the nearest-neighbour frame scaler: scripted beats, random frames and sweeps.
module tb_nearest_neighbor_frame_scaler;
	import nnfs_pkg::*;

	localparam int MAX_W           = DEF_MAX_WIDTH;
	localparam int MAX_H           = DEF_MAX_HEIGHT;
	localparam int SETTLE_CYCLES   = 40;
	localparam int CYCLE_LIMIT     = 2_500_000;
	localparam int RANDOM_BEATS    = 1200;
	localparam int PRESSURE_AT     = 60;        // result count at which the receiver holds off
	localparam int PRESSURE_CYCLES = 600;

	// One output beat as the scaler should produce it
	typedef struct packed {
		logic [PIX_OUT_W-1:0] pixel;
		logic [POS_OUT_W-1:0] x;
		logic [POS_OUT_W-1:0] y;
		logic                 last;
		logic                 complete;
	} scaled_pixel_t;

	typedef enum logic {ROW_REG, ROW_BEAT} row_kind_e;

	// Scripted step: a size register write or an input beat, optionally with its result typed in
	typedef struct packed {
		row_kind_e            kind;
		logic                 typed;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     val;
		logic                 cmd;
		logic [PIX_IN_W-1:0]  pix;
		scaled_pixel_t        want;
	} script_row_t;

	localparam script_row_t DIRECTED [0:22] = '{
		// full-size frame straight after reset, nothing loaded yet
		'{ROW_BEAT, 1'b0, '0, '0, CMD_LOAD, 24'hFFFFFF, '0},
		'{ROW_BEAT, 1'b1, '0, '0, CMD_EMIT, 24'h000000, '{24'hFFFFFF, 10'd0, 10'd0, 1'b0, 1'b0}},
		// zero acts as one, oversize acts as the maximum
		'{ROW_REG,  1'b0, REG_SRC_W, 11'd0,    CMD_LOAD, '0, '0},
		'{ROW_REG,  1'b0, REG_SRC_H, 11'd0,    CMD_LOAD, '0, '0},
		'{ROW_REG,  1'b0, REG_DST_W, 11'd2047, CMD_LOAD, '0, '0},
		'{ROW_REG,  1'b0, REG_DST_H, 11'd2,    CMD_LOAD, '0, '0},
		'{ROW_BEAT, 1'b1, '0, '0, CMD_EMIT, 24'h000000, '{24'hFFFFFF, 10'd1, 10'd0, 1'b0, 1'b0}},
		// one-pixel source completes on a single load
		'{ROW_BEAT, 1'b0, '0, '0, CMD_LOAD, 24'h000000, '0},
		'{ROW_BEAT, 1'b1, '0, '0, CMD_EMIT, 24'hFFFFFF, '{24'hFFFFFF, 10'd2, 10'd0, 1'b0, 1'b1}},
		'{ROW_BEAT, 1'b0, '0, '0, CMD_LOAD, 24'h000000, '0},
		'{ROW_BEAT, 1'b1, '0, '0, CMD_EMIT, 24'h000000, '{24'h000000, 10'd3, 10'd0, 1'b0, 1'b1}},
		// shrink the target mid-row: column past the end saturates and wraps
		'{ROW_REG,  1'b0, REG_DST_W, 11'd3,    CMD_LOAD, '0, '0},
		'{ROW_BEAT, 1'b1, '0, '0, CMD_EMIT, 24'h000000, '{24'h000000, 10'd4, 10'd0, 1'b0, 1'b1}},
		'{ROW_BEAT, 1'b1, '0, '0, CMD_EMIT, 24'h000000, '{24'h000000, 10'd0, 10'd1, 1'b0, 1'b1}},
		'{ROW_BEAT, 1'b0, '0, '0, CMD_EMIT, 24'hFFFFFF, '0},
		'{ROW_BEAT, 1'b1, '0, '0, CMD_EMIT, 24'h000000, '{24'h000000, 10'd2, 10'd1, 1'b1, 1'b1}},
		// back to maximum source, one-column target
		'{ROW_REG,  1'b0, REG_SRC_W, 11'd2047, CMD_LOAD, '0, '0},
		'{ROW_REG,  1'b0, REG_SRC_H, 11'd2047, CMD_LOAD, '0, '0},
		'{ROW_REG,  1'b0, REG_DST_W, 11'd0,    CMD_LOAD, '0, '0},
		'{ROW_REG,  1'b0, REG_DST_H, 11'd2047, CMD_LOAD, '0, '0},
		'{ROW_BEAT, 1'b0, '0, '0, CMD_LOAD, 24'h5A5A5A, '0},
		'{ROW_BEAT, 1'b0, '0, '0, CMD_LOAD, 24'hA5A5A5, '0},
		'{ROW_BEAT, 1'b1, '0, '0, CMD_EMIT, 24'h000000, '{24'h5A5A5A, 10'd0, 10'd0, 1'b0, 1'b1}}
	};

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic                 command   = CMD_LOAD;
	logic [PIX_IN_W-1:0]  pixel_in  = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [PIX_OUT_W-1:0] pixel_out;
	logic [POS_OUT_W-1:0] target_x;
	logic [POS_OUT_W-1:0] target_y;
	logic                 frame_last;
	logic                 source_complete;

	// Scaler shadow state
	logic [CFG_W-1:0]     src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
	logic [POS_OUT_W-1:0] load_x, load_y, emit_x, emit_y;
	logic                 frame_full;
	logic [PIX_IN_W-1:0]  source_store [int];
	scaled_pixel_t        pending_pixels [$];

	int mismatches   = 0;
	int results_seen = 0;
	int beats_sent   = 0;
	int tx_burst     = 0;
	int rx_burst     = 0;

	nearest_neighbor_frame_scaler uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Size register as the scaler uses it
	function automatic int eff_dim(input logic [CFG_W-1:0] v, input int maxv);
		if (v == '0) return 1;
		return (int'(v) > maxv) ? maxv : int'(v);
	endfunction

	function automatic int nearest_src(input int pos, input int src, input int dst);
		int s;
		s = (pos * src) / dst;
		return (s >= src) ? src - 1 : s;
	endfunction

	// Store entry that the next emit beat samples
	function automatic int emit_key();
		int sx, sy;
		sx = nearest_src(int'(emit_x), eff_dim(src_w_reg, MAX_W), eff_dim(dst_w_reg, MAX_W));
		sy = nearest_src(int'(emit_y), eff_dim(src_h_reg, MAX_H), eff_dim(dst_h_reg, MAX_H));
		return sy * MAX_W + sx;
	endfunction

	// Apply one accepted beat to the shadow state; returns 1 when it gives a result
	function automatic bit advance_scaler(input logic cmd, input logic [PIX_IN_W-1:0] pix,
			output scaled_pixel_t res);
		int  sw, sh, tw, th;
		bit  row_end;
		sw  = eff_dim(src_w_reg, MAX_W);
		sh  = eff_dim(src_h_reg, MAX_H);
		tw  = eff_dim(dst_w_reg, MAX_W);
		th  = eff_dim(dst_h_reg, MAX_H);
		res = '0;
		if (cmd == CMD_LOAD) begin
			source_store[int'(load_y) * MAX_W + int'(load_x)] = pix;
			if (int'(load_x) + 1 >= sw) begin
				load_x = '0;
				if (int'(load_y) + 1 >= sh) begin
					load_y     = '0;
					frame_full = 1'b1;
				end else begin
					load_y = load_y + 1'b1;
				end
			end else begin
				load_x = load_x + 1'b1;
			end
			return 1'b0;
		end
		row_end      = (int'(emit_x) + 1 >= tw);
		res.pixel    = source_store[emit_key()];
		res.x        = emit_x;
		res.y        = emit_y;
		res.last     = row_end && (int'(emit_y) + 1 >= th);
		res.complete = frame_full;
		if (row_end) begin
			emit_y = res.last ? '0 : emit_y + 1'b1;
			emit_x = '0;
		end else begin
			emit_x = emit_x + 1'b1;
		end
		return 1'b1;
	endfunction

	// Idle length: mostly none or short, a few long, with bursts of none at all
	function automatic int idle_gap(inout int burst);
		int r;
		if (burst > 0) begin
			burst--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 8) begin
			burst = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [CFG_W-1:0] random_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return CFG_W'($urandom_range(1, 8));
		if (r < 82) return CFG_W'($urandom_range(9, 40));
		if (r < 90) return '0;
		if (r < 95) return DIM_RESET;
		return CFG_W'($urandom_range(1025, 2047));
	endfunction

	task automatic write_size(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_SRC_W: src_w_reg = val;
			REG_SRC_H: src_h_reg = val;
			REG_DST_W: dst_w_reg = val;
			REG_DST_H: dst_h_reg = val;
			default: ;
		endcase
	endtask

	// Drain every outstanding result, then allow for a load still in flight
	task automatic wait_idle();
		in_valid  <= 1'b0;
		cfg_write <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_beat(input logic cmd, input logic [PIX_IN_W-1:0] pix,
			output bit made, output scaled_pixel_t res);
		int gap;
		gap = idle_gap(tx_burst);
		cfg_write <= 1'b0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		pixel_in <= pix;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		beats_sent++;
		made = advance_scaler(cmd, pix, res);
	endtask

	task automatic feed(input logic cmd, input logic [PIX_IN_W-1:0] pix);
		scaled_pixel_t res;
		bit            made;
		send_beat(cmd, pix, made, res);
		if (made) pending_pixels.push_back(res);
	endtask

	task automatic emit_or_fill();
		logic [PIX_IN_W-1:0] pix;
		pix = PIX_IN_W'($urandom);
		// an emit that would sample a never-written entry becomes a load
		if (source_store.exists(emit_key())) feed(CMD_EMIT, pix);
		else feed(CMD_LOAD, pix);
	endtask

	task automatic new_sizes();
		logic [CFG_W-1:0] sw, sh, tw, th;
		sw = random_size();
		sh = random_size();
		tw = random_size();
		th = random_size();
		// keep frames short when one side is large
		if (eff_dim(sw, MAX_W) * eff_dim(sh, MAX_H) > 1100) sh = CFG_W'(1);
		if (eff_dim(tw, MAX_W) * eff_dim(th, MAX_H) > 1100) th = CFG_W'(1);
		wait_idle();
		write_size(REG_SRC_W, sw);
		write_size(REG_SRC_H, sh);
		write_size(REG_DST_W, tw);
		write_size(REG_DST_H, th);
	endtask

	// Whole source frame, then up to 200 destination pixels with stray loads mixed in
	task automatic run_frame();
		int loads, emits;
		loads = eff_dim(src_w_reg, MAX_W) * eff_dim(src_h_reg, MAX_H);
		emits = eff_dim(dst_w_reg, MAX_W) * eff_dim(dst_h_reg, MAX_H);
		if (emits > 200) emits = 200;
		repeat (loads) feed(CMD_LOAD, PIX_IN_W'($urandom));
		repeat (emits) begin
			if ($urandom_range(0, 6) == 0) feed(CMD_LOAD, PIX_IN_W'($urandom));
			emit_or_fill();
		end
	endtask

	// Stimulus
	initial begin : stimulus
		scaled_pixel_t res;
		bit            made;
		bit            last_was_reg;
		int            base;
		src_w_reg    = DIM_RESET;
		src_h_reg    = DIM_RESET;
		dst_w_reg    = DIM_RESET;
		dst_h_reg    = DIM_RESET;
		load_x       = '0;
		load_y       = '0;
		emit_x       = '0;
		emit_y       = '0;
		frame_full   = 1'b0;
		last_was_reg = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// scripted part
		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].kind == ROW_REG) begin
				if (!last_was_reg) wait_idle();
				write_size(DIRECTED[i].idx, DIRECTED[i].val);
				last_was_reg = 1'b1;
			end else begin
				send_beat(DIRECTED[i].cmd, DIRECTED[i].pix, made, res);
				if (made) pending_pixels.push_back(DIRECTED[i].typed ? DIRECTED[i].want : res);
				last_was_reg = 1'b0;
			end
		end

		// random frames, some well formed, some a loose mix of commands
		base = beats_sent;
		while (beats_sent - base < RANDOM_BEATS) begin
			new_sizes();
			if ($urandom_range(0, 9) < 7) begin
				run_frame();
			end else begin
				repeat ($urandom_range(10, 60)) begin
					if ($urandom_range(0, 1) != 0) emit_or_fill();
					else feed(CMD_LOAD, PIX_IN_W'($urandom));
				end
			end
		end

		// one-row sweep to the last column, then one-column sweep to the last row
		wait_idle();
		write_size(REG_SRC_W, CFG_W'(1));
		write_size(REG_SRC_H, CFG_W'(1));
		write_size(REG_DST_W, DIM_RESET);
		write_size(REG_DST_H, CFG_W'(1));
		feed(CMD_LOAD, PIX_IN_W'($urandom));
		repeat (MAX_W + 1) emit_or_fill();
		wait_idle();
		write_size(REG_DST_W, CFG_W'(1));
		write_size(REG_DST_H, DIM_RESET);
		repeat (MAX_H + 1) emit_or_fill();

		wait_idle();
		if (mismatches == 0) begin
			$display("** nearest_neighbor_frame_scaler: PASSED **");
		end else begin
			$display("** nearest_neighbor_frame_scaler: FAILED **");
		end
		$finish;
	end

	// Result side: random stalls, one long hold-off, field-by-field compare
	initial begin : result_drain
		scaled_pixel_t want;
		int            hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (pending_pixels.size() == 0) begin
					$error("result beat with nothing expected: x=%0d y=%0d", target_x, target_y);
					mismatches++;
				end else begin
					want = pending_pixels.pop_front();
					if (pixel_out !== want.pixel) begin
						$error("pixel_out: expected %h, got %h", want.pixel, pixel_out);
						mismatches++;
					end
					if (target_x !== want.x) begin
						$error("target_x: expected %0d, got %0d", want.x, target_x);
						mismatches++;
					end
					if (target_y !== want.y) begin
						$error("target_y: expected %0d, got %0d", want.y, target_y);
						mismatches++;
					end
					if (frame_last !== want.last) begin
						$error("frame_last: expected %b, got %b", want.last, frame_last);
						mismatches++;
					end
					if (source_complete !== want.complete) begin
						$error("source_complete: expected %b, got %b", want.complete,
							source_complete);
						mismatches++;
					end
				end
				results_seen++;
				hold = (results_seen == PRESSURE_AT) ? PRESSURE_CYCLES : idle_gap(rx_burst);
			end else if (hold > 0) begin
				hold--;
			end
			out_ready <= (hold == 0);
		end
	end

	// Watchdog
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$error("timeout after %0d cycles, %0d results outstanding", cycles,
			pending_pixels.size());
		$display("** nearest_neighbor_frame_scaler: FAILED **");
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/nnfs_pkg.sv
rtl/core/nnfs_ram.sv
rtl/core/nnfs_div.sv
rtl/core/nearest_neighbor_frame_scaler.sv
rtl/core/nnfs_checker.sv
sim/tb_nearest_neighbor_frame_scaler.sv
